[src/mi4_pkg.sv]
package mi4_pkg;

    localparam int ADDR_W    = 6;
    localparam int MEM_DEPTH = 64;
    localparam int DATA_W    = 32;

    // Working store map: transposed elements, pair products, cofactors, scratch.
    localparam logic [ADDR_W-1:0] P_BASE   = 6'd16;
    localparam logic [ADDR_W-1:0] P_HIGH   = 6'd28;
    localparam logic [ADDR_W-1:0] COF_BASE = 6'd40;
    localparam logic [ADDR_W-1:0] TMP_BASE = 6'd56;
    localparam logic [ADDR_W-1:0] DET_ADDR = 6'd56;
    localparam logic [ADDR_W-1:0] PRD_ADDR = 6'd57;
    localparam logic [ADDR_W-1:0] SUM_ADDR = 6'd59;
    localparam logic [ADDR_W-1:0] INV_ADDR = 6'd62;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_ADD,
        FOP_SUB,
        FOP_RCP
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef enum logic [2:0] {
        SEG_PAIR,
        SEG_COF,
        SEG_DET,
        SEG_RCP,
        SEG_EMIT
    } seg_t;

    typedef struct packed {
        fpu_op_t           op;
        logic [ADDR_W-1:0] src_a;
        logic [ADDR_W-1:0] src_b;
        logic [ADDR_W-1:0] dst;
        logic              emit;
        logic              last;
    } instr_t;

    localparam logic [3:0] PAIR_SRC [24][2] = '{
        '{4'd10, 4'd15}, '{4'd11, 4'd14}, '{4'd9,  4'd15}, '{4'd11, 4'd13},
        '{4'd9,  4'd14}, '{4'd10, 4'd13}, '{4'd8,  4'd15}, '{4'd11, 4'd12},
        '{4'd8,  4'd14}, '{4'd10, 4'd12}, '{4'd8,  4'd13}, '{4'd9,  4'd12},
        '{4'd2,  4'd7},  '{4'd3,  4'd6},  '{4'd1,  4'd7},  '{4'd3,  4'd5},
        '{4'd1,  4'd6},  '{4'd2,  4'd5},  '{4'd0,  4'd7},  '{4'd3,  4'd4},
        '{4'd0,  4'd6},  '{4'd2,  4'd4},  '{4'd0,  4'd5},  '{4'd1,  4'd4}
    };

    localparam logic [3:0] COF_SRC [16][12] = '{
        '{4'd0, 4'd5, 4'd3, 4'd6, 4'd4, 4'd7, 4'd1, 4'd5, 4'd2, 4'd6, 4'd5, 4'd7},
        '{4'd1, 4'd4, 4'd6, 4'd6, 4'd9, 4'd7, 4'd0, 4'd4, 4'd7, 4'd6, 4'd8, 4'd7},
        '{4'd2, 4'd4, 4'd7, 4'd5, 4'd10, 4'd7, 4'd3, 4'd4, 4'd6, 4'd5, 4'd11, 4'd7},
        '{4'd5, 4'd4, 4'd8, 4'd5, 4'd11, 4'd6, 4'd4, 4'd4, 4'd9, 4'd5, 4'd10, 4'd6},
        '{4'd1, 4'd1, 4'd2, 4'd2, 4'd5, 4'd3, 4'd0, 4'd1, 4'd3, 4'd2, 4'd4, 4'd3},
        '{4'd0, 4'd0, 4'd7, 4'd2, 4'd8, 4'd3, 4'd1, 4'd0, 4'd6, 4'd2, 4'd9, 4'd3},
        '{4'd3, 4'd0, 4'd6, 4'd1, 4'd11, 4'd3, 4'd2, 4'd0, 4'd7, 4'd1, 4'd10, 4'd3},
        '{4'd4, 4'd0, 4'd9, 4'd1, 4'd10, 4'd2, 4'd5, 4'd0, 4'd8, 4'd1, 4'd11, 4'd2},
        '{4'd0, 4'd13, 4'd3, 4'd14, 4'd4, 4'd15, 4'd1, 4'd13, 4'd2, 4'd14, 4'd5, 4'd15},
        '{4'd1, 4'd12, 4'd6, 4'd14, 4'd9, 4'd15, 4'd0, 4'd12, 4'd7, 4'd14, 4'd8, 4'd15},
        '{4'd2, 4'd12, 4'd7, 4'd13, 4'd10, 4'd15, 4'd3, 4'd12, 4'd6, 4'd13, 4'd11, 4'd15},
        '{4'd5, 4'd12, 4'd8, 4'd13, 4'd11, 4'd14, 4'd4, 4'd12, 4'd9, 4'd13, 4'd10, 4'd14},
        '{4'd2, 4'd10, 4'd5, 4'd11, 4'd1, 4'd9, 4'd4, 4'd11, 4'd0, 4'd9, 4'd3, 4'd10},
        '{4'd8, 4'd11, 4'd0, 4'd8, 4'd7, 4'd10, 4'd6, 4'd10, 4'd9, 4'd11, 4'd1, 4'd8},
        '{4'd6, 4'd9, 4'd11, 4'd11, 4'd3, 4'd8, 4'd10, 4'd11, 4'd2, 4'd8, 4'd7, 4'd9},
        '{4'd10, 4'd10, 4'd4, 4'd8, 4'd9, 4'd9, 4'd8, 4'd9, 4'd11, 4'd10, 4'd5, 4'd8}
    };

    function automatic instr_t fetch_instr(input seg_t seg, input logic [4:0] idx,
                                           input logic [3:0] step);
        instr_t            ins;
        logic [ADDR_W-1:0] base;
        logic [3:0]        row;
        ins  = '0;
        row  = idx[3:0];
        base = idx[3] ? P_HIGH : P_BASE;
        ins.op = FOP_MUL;
        unique case (seg)
            SEG_PAIR:
            begin
                ins.src_a = 6'(PAIR_SRC[idx][0]);
                ins.src_b = 6'(PAIR_SRC[idx][1]);
                ins.dst   = P_BASE + 6'(idx);
            end
            SEG_COF:
            begin
                if (step < 4'd6)
                begin
                    ins.src_a = base + 6'(COF_SRC[row][{step[2:0], 1'b0}]);
                    ins.src_b = 6'(COF_SRC[row][{step[2:0], 1'b1}]);
                    ins.dst   = TMP_BASE + 6'(step);
                end
                else
                begin
                    ins.op = FOP_ADD;
                    priority case (step)
                        4'd6:
                        begin
                            ins.src_a = TMP_BASE;
                            ins.src_b = TMP_BASE + 6'd1;
                            ins.dst   = TMP_BASE;
                        end
                        4'd7:
                        begin
                            ins.src_a = TMP_BASE;
                            ins.src_b = TMP_BASE + 6'd2;
                            ins.dst   = TMP_BASE;
                        end
                        4'd8:
                        begin
                            ins.src_a = SUM_ADDR;
                            ins.src_b = SUM_ADDR + 6'd1;
                            ins.dst   = SUM_ADDR;
                        end
                        4'd9:
                        begin
                            ins.src_a = SUM_ADDR;
                            ins.src_b = SUM_ADDR + 6'd2;
                            ins.dst   = SUM_ADDR;
                        end
                        default:
                        begin
                            ins.op    = FOP_SUB;
                            ins.src_a = TMP_BASE;
                            ins.src_b = SUM_ADDR;
                            ins.dst   = COF_BASE + 6'(row);
                        end
                    endcase
                end
            end
            SEG_DET:
            begin
                priority case (step)
                    4'd0:
                    begin
                        ins.src_a = 6'd0;
                        ins.src_b = COF_BASE;
                        ins.dst   = DET_ADDR;
                    end
                    4'd1, 4'd3, 4'd5:
                    begin
                        ins.src_a = 6'(step[2:1]) + 6'd1;
                        ins.src_b = COF_BASE + 6'(step[2:1]) + 6'd1;
                        ins.dst   = PRD_ADDR;
                    end
                    default:
                    begin
                        ins.op    = FOP_ADD;
                        ins.src_a = DET_ADDR;
                        ins.src_b = PRD_ADDR;
                        ins.dst   = DET_ADDR;
                    end
                endcase
            end
            SEG_RCP:
            begin
                ins.op    = FOP_RCP;
                ins.src_a = DET_ADDR;
                ins.src_b = DET_ADDR;
                ins.dst   = INV_ADDR;
            end
            SEG_EMIT:
            begin
                ins.src_a = COF_BASE + 6'(row);
                ins.src_b = INV_ADDR;
                ins.emit  = 1'b1;
                ins.last  = (row == 4'd15);
            end
            default:
            begin
                ins = '0;
            end
        endcase
        return ins;
    endfunction

    function automatic logic [5:0] lead_pos50(input logic [49:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [4:0] lead_pos24(input logic [23:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Rounds a significand with its leading one at bit 26 (bits 2:0 guard,
    // round, sticky) to nearest even, handling subnormal and overflow results.
    function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                             input logic [26:0] sig);
        logic [26:0] s;
        logic [26:0] mask;
        logic [5:0]  sh;
        logic [24:0] m;
        logic        up;
        logic [31:0] res;
        if (e >= 12'sd255)
        begin
            res = {sign, 8'hFF, 23'd0};
        end
        else if (e <= 12'sd0)
        begin
            sh   = (e < -12'sd30) ? 6'd31 : 6'(12'sd1 - e);
            s    = sig >> sh;
            mask = (27'd1 << sh) - 27'd1;
            s[0] = s[0] | (|(sig & mask));
            up   = s[2] & (s[1] | s[0] | s[3]);
            m    = {1'b0, s[26:3]} + 25'(up);
            res  = {sign, 7'd0, m[23], m[22:0]};
        end
        else
        begin
            up = sig[2] & (sig[1] | sig[0] | sig[3]);
            m  = {1'b0, sig[26:3]} + 25'(up);
            if (m[24])
            begin
                if (e == 12'sd254)
                begin
                    res = {sign, 8'hFF, 23'd0};
                end
                else
                begin
                    res = {sign, 8'(e + 12'sd1), 23'd0};
                end
            end
            else
            begin
                res = {sign, e[7:0], m[22:0]};
            end
        end
        return res;
    endfunction

endpackage

[src/mi4_ram.sv]
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[src/mi4_fpu.sv]
module mi4_fpu (
    input  logic             clk,
    input  logic             rst_n,
    input  mi4_pkg::fpu_req_t req,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic             done,
    output logic [31:0]      result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_RND
    } state_t;

    state_t             state_reg;
    logic               done_reg;
    logic [31:0]        result_reg;
    logic               spec_reg;
    logic [31:0]        spec_val_reg;
    logic               sign_reg;
    logic               zsign_reg;
    logic               zero_reg;
    logic signed [11:0] e_reg;
    logic signed [11:0] ne_reg;
    logic [49:0]        mag_reg;
    logic [26:0]        sig_reg;
    logic [23:0]        d_reg;
    logic [25:0]        r_reg;
    logic [48:0]        q_reg;
    logic [5:0]         cnt_reg;

    logic               sa, sb, sb_eff;
    logic [7:0]         ea, eb, ea_eff, eb_eff;
    logic [23:0]        ma, mb;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [47:0]        mul_prod;
    logic signed [11:0] mul_e;
    logic               a_big;
    logic [7:0]         e_big, e_small, e_diff;
    logic [5:0]         shamt;
    logic [49:0]        big_v, small_v, small_sh, small_mask, add_mag;
    logic               add_sign;
    logic [4:0]         rcp_lead;
    logic [23:0]        rcp_d;
    logic signed [11:0] rcp_e;
    logic               div_ge;
    logic [25:0]        div_r_sub, div_r_next;
    logic [48:0]        div_q_next;
    logic [5:0]         norm_p;
    logic [49:0]        norm_n;

    always_comb
    begin
        sa     = a[31];
        sb     = b[31];
        sb_eff = b[31] ^ (req.op == mi4_pkg::FOP_SUB);
        ea     = a[30:23];
        eb     = b[30:23];
        ea_eff = (ea == 8'd0) ? 8'd1 : ea;
        eb_eff = (eb == 8'd0) ? 8'd1 : eb;
        ma     = {ea != 8'd0, a[22:0]};
        mb     = {eb != 8'd0, b[22:0]};
        nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
        zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);

        mul_prod = ma * mb;
        mul_e    = $signed({4'd0, ea_eff}) + $signed({4'd0, eb_eff}) - 12'sd127;

        a_big      = {ea_eff, ma} >= {eb_eff, mb};
        e_big      = a_big ? ea_eff : eb_eff;
        e_small    = a_big ? eb_eff : ea_eff;
        e_diff     = e_big - e_small;
        shamt      = (e_diff > 8'd63) ? 6'd63 : e_diff[5:0];
        big_v      = {1'b0, (a_big ? ma : mb), 25'd0};
        small_v    = {1'b0, (a_big ? mb : ma), 25'd0};
        small_mask = (50'd1 << shamt) - 50'd1;
        small_sh   = small_v >> shamt;
        small_sh[0] = small_sh[0] | (|(small_v & small_mask));
        add_mag    = (sa == sb_eff) ? (big_v + small_sh) : (big_v - small_sh);
        add_sign   = a_big ? sa : sb_eff;

        rcp_lead = mi4_pkg::lead_pos24(mb);
        rcp_d    = mb << (5'd23 - rcp_lead);
        rcp_e    = 12'sd276 - $signed({4'd0, eb_eff}) - $signed({7'd0, rcp_lead});

        div_ge     = r_reg >= {2'b00, d_reg};
        div_r_sub  = div_ge ? (r_reg - {2'b00, d_reg}) : r_reg;
        div_r_next = {div_r_sub[24:0], 1'b0};
        div_q_next = {q_reg[47:0], div_ge};

        norm_p = mi4_pkg::lead_pos50(mag_reg);
        norm_n = mag_reg << (6'd49 - norm_p);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= ST_NORM;
                        unique case (req.op)
                            mi4_pkg::FOP_MUL:
                            begin
                                spec_reg     <= nan_a | nan_b | inf_a | inf_b;
                                spec_val_reg <= (nan_a | nan_b | (inf_a & zero_b)
                                                 | (zero_a & inf_b))
                                                ? mi4_pkg::CANON_NAN
                                                : {sa ^ sb, 8'hFF, 23'd0};
                                sign_reg     <= sa ^ sb;
                                zsign_reg    <= sa ^ sb;
                                e_reg        <= mul_e;
                                mag_reg      <= {mul_prod, 2'b00};
                            end
                            mi4_pkg::FOP_ADD, mi4_pkg::FOP_SUB:
                            begin
                                spec_reg     <= nan_a | nan_b | inf_a | inf_b;
                                spec_val_reg <= (nan_a | nan_b | (inf_a & inf_b
                                                 & (sa != sb_eff)))
                                                ? mi4_pkg::CANON_NAN
                                                : {(inf_a ? sa : sb_eff), 8'hFF, 23'd0};
                                sign_reg     <= add_sign;
                                zsign_reg    <= sa & sb_eff;
                                e_reg        <= $signed({4'd0, e_big});
                                mag_reg      <= add_mag;
                            end
                            mi4_pkg::FOP_RCP:
                            begin
                                spec_reg     <= nan_b | zero_b | inf_b;
                                spec_val_reg <= nan_b ? mi4_pkg::CANON_NAN
                                                : (zero_b ? 32'd0 : {sb, 31'd0});
                                sign_reg     <= sb;
                                zsign_reg    <= sb;
                                e_reg        <= rcp_e;
                                d_reg        <= rcp_d;
                                r_reg        <= 26'h080_0000;
                                q_reg        <= '0;
                                cnt_reg      <= 6'd48;
                                if (!(nan_b | zero_b | inf_b))
                                begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            default:
                            begin
                                spec_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    r_reg   <= div_r_next;
                    q_reg   <= div_q_next;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        mag_reg   <= {div_q_next, div_r_next != 26'd0};
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    zero_reg  <= (mag_reg == 50'd0);
                    sig_reg   <= {norm_n[49:24], |norm_n[23:0]};
                    ne_reg    <= e_reg + $signed({6'd0, norm_p}) - 12'sd48;
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    if (spec_reg)
                    begin
                        result_reg <= spec_val_reg;
                    end
                    else if (zero_reg)
                    begin
                        result_reg <= {zsign_reg, 31'd0};
                    end
                    else
                    begin
                        result_reg <= mi4_pkg::fp_round(sign_reg, ne_reg, sig_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/matrix_inverse_4x4.sv]
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   element_bits
// output    out        out_valid/out_stall result_bits, result_last
//
// Each of the sixteen element beats is taken when valid and written to the store.
// After the sixteenth beat one shared floating-point unit runs 224 operations out of the
// store, one at a time.
// The input is stalled from the sixteenth beat until the last result is registered.
// Reset clears the load count and control state; the element store has no reset value.
// A stalled output holds the sequencer at the pending result.
module matrix_inverse_4x4 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] element_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits,
    output logic        result_last
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ISSUE,
        S_START,
        S_WAIT,
        S_PUT
    } state_t;

    state_t                     state_reg;
    logic [3:0]                 load_cnt_reg;
    mi4_pkg::seg_t              seg_reg, seg_next;
    logic [4:0]                 idx_reg, idx_next;
    logic [3:0]                 step_reg, step_next;
    logic                       out_valid_reg;
    logic [31:0]                out_bits_reg;
    logic                       out_last_reg;
    logic [31:0]                hold_reg;

    mi4_pkg::instr_t            instr;
    logic [3:0]                 last_step;
    logic [4:0]                 idx_max;
    logic                       in_take;
    logic                       out_free;
    logic                       ram_we;
    logic [mi4_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                ram_wdata;
    logic [31:0]                rdata_a, rdata_b;
    mi4_pkg::fpu_req_t          fpu_req;
    logic                       fpu_done;
    logic [31:0]                fpu_result;

    always_comb
    begin
        instr = mi4_pkg::fetch_instr(seg_reg, idx_reg, step_reg);
        unique case (seg_reg)
            mi4_pkg::SEG_PAIR: begin last_step = 4'd0;  idx_max = 5'd23; end
            mi4_pkg::SEG_COF:  begin last_step = 4'd10; idx_max = 5'd15; end
            mi4_pkg::SEG_DET:  begin last_step = 4'd6;  idx_max = 5'd0;  end
            mi4_pkg::SEG_EMIT: begin last_step = 4'd0;  idx_max = 5'd15; end
            default:           begin last_step = 4'd0;  idx_max = 5'd0;  end
        endcase

        step_next = step_reg + 4'd1;
        idx_next  = idx_reg;
        seg_next  = seg_reg;
        if (step_reg == last_step)
        begin
            step_next = 4'd0;
            idx_next  = idx_reg + 5'd1;
            if (idx_reg == idx_max)
            begin
                idx_next = 5'd0;
                unique case (seg_reg)
                    mi4_pkg::SEG_PAIR: seg_next = mi4_pkg::SEG_COF;
                    mi4_pkg::SEG_COF:  seg_next = mi4_pkg::SEG_DET;
                    mi4_pkg::SEG_DET:  seg_next = mi4_pkg::SEG_RCP;
                    mi4_pkg::SEG_RCP:  seg_next = mi4_pkg::SEG_EMIT;
                    default:           seg_next = mi4_pkg::SEG_PAIR;
                endcase
            end
        end

        in_take  = in_valid && (state_reg == S_LOAD);
        out_free = !out_valid_reg || !out_stall;

        if (state_reg == S_LOAD)
        begin
            ram_we    = in_take;
            ram_waddr = {2'b00, load_cnt_reg[1:0], load_cnt_reg[3:2]};
            ram_wdata = element_bits;
        end
        else
        begin
            ram_we    = (state_reg == S_WAIT) && fpu_done && !instr.emit;
            ram_waddr = instr.dst;
            ram_wdata = fpu_result;
        end

        fpu_req.start = (state_reg == S_START);
        fpu_req.op    = instr.op;
    end

    mi4_ram #(
        .WIDTH (mi4_pkg::DATA_W),
        .DEPTH (mi4_pkg::MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (instr.src_a),
        .raddr_b (instr.src_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mi4_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fpu_req),
        .a      (rdata_a),
        .b      (rdata_b),
        .done   (fpu_done),
        .result (fpu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= 4'd0;
            seg_reg       <= mi4_pkg::SEG_PAIR;
            idx_reg       <= 5'd0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_take)
                    begin
                        load_cnt_reg <= load_cnt_reg + 4'd1;
                        if (load_cnt_reg == 4'd15)
                        begin
                            seg_reg   <= mi4_pkg::SEG_PAIR;
                            idx_reg   <= 5'd0;
                            step_reg  <= 4'd0;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (fpu_done)
                    begin
                        if (instr.emit)
                        begin
                            hold_reg  <= fpu_result;
                            state_reg <= S_PUT;
                        end
                        else
                        begin
                            seg_reg   <= seg_next;
                            idx_reg   <= idx_next;
                            step_reg  <= step_next;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bits_reg  <= hold_reg;
                        out_last_reg  <= instr.last;
                        seg_reg       <= seg_next;
                        idx_reg       <= idx_next;
                        step_reg      <= step_next;
                        state_reg     <= instr.last ? S_LOAD : S_ISSUE;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_LOAD);
    assign out_valid   = out_valid_reg;
    assign result_bits = out_bits_reg;
    assign result_last = out_last_reg;

endmodule
